// ----- hdl/opd_pkg.sv -----
package opd_pkg;

  localparam int MAX_SEGMENTS_DEF = 255;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] DEFAULT_RATE = 32'd16000;
  localparam logic [15:0] DEFAULT_MAX_PKT = 16'd8192;

  localparam logic [39:0] SYNC_PAGE = 40'h4F67675300;
  localparam logic [63:0] MAGIC_HEAD = 64'h646165487375704F;
  localparam logic [63:0] MAGIC_TAGS = 64'h736761547375704F;
  localparam logic [4:0] SYNC_LEN = 5'd5;
  localparam logic [4:0] COUNT_BYTE_POS = 5'd26;
  localparam logic [7:0] LACE_FULL = 8'd255;
  localparam logic [15:0] HEAD_MIN_LEN = 16'd19;
  localparam logic [15:0] MAGIC_LEN = 16'd8;
  localparam logic [15:0] RATE_FIRST = 16'd12;
  localparam logic [15:0] RATE_LAST = 16'd15;

  localparam logic CFG_DEFAULT_RATE = 1'b0;
  localparam logic CFG_MAX_PKT = 1'b1;

  localparam logic [1:0] KIND_HEAD = 2'd0;
  localparam logic [1:0] KIND_TAGS = 2'd1;
  localparam logic [1:0] KIND_AUDIO = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK = 2'd1;
  localparam logic [1:0] ST_SIZE_ERR = 2'd2;
  localparam logic [1:0] ST_NO_AUDIO = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_TABLE,
    PH_BODY,
    PH_ADV,
    PH_LOOK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic take;
    logic fin;
    logic do_fin;
    logic raise;
    logic re;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic byte_valid;
    logic packet_end;
    logic [1:0] packet_kind;
    logic [31:0] packet_rate;
    logic [1:0] stream_status;
  } result_t;

endpackage

// ----- hdl/opd_ram.sv -----
module opd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input logic clk,
  input logic we,
  input logic [AW-1:0] waddr,
  input logic [WIDTH-1:0] wdata,
  input logic re,
  input logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/opd_fifo.sv -----
module opd_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = opd_pkg::QUEUE_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [WIDTH-1:0] in_data,
  output logic out_valid,
  input logic out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/opd_parser.sv -----
module opd_parser #(
  parameter int MAX_SEGMENTS = opd_pkg::MAX_SEGMENTS_DEF
) (
  input logic clk,
  input logic rst,
  input logic [31:0] default_rate,
  input logic [15:0] max_pkt,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] in_byte,
  input logic in_last,
  output logic out_valid,
  input logic out_ready,
  output opd_pkg::result_t out_res
);
  import opd_pkg::*;

  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  phase_t phase, phase_next;
  ctrl_t ctrl;

  logic [39:0] window, window_next;
  logic [4:0] hdr_pos, hdr_pos_next;
  logic [7:0] seg_total, seg_total_next;
  logic [7:0] seg_pos, seg_pos_next;
  logic [7:0] seg_left, seg_left_next;
  logic [7:0] cur_len, cur_len_next;
  logic [15:0] pkt_len, pkt_len_next;
  logic [63:0] prefix, prefix_next;
  logic [31:0] rate_bytes, rate_bytes_next;
  logic head_flag, head_flag_next;
  logic tags_flag, tags_flag_next;
  logic [31:0] stream_rate, stream_rate_next;
  logic audio_found, audio_found_next;
  logic pend_bv, pend_bv_next;
  logic [7:0] pend_byte, pend_byte_next;
  logic pend_end, pend_end_next;
  logic [1:0] pend_kind, pend_kind_next;
  logic pend_last, pend_last_next;
  logic pend_fin, pend_fin_next;

  logic can_load;
  logic last_flag;
  logic [39:0] window_shift;
  logic [7:0] seg_pos_inc;
  logic [7:0] rdata;
  logic [16:0] look_sum;
  logic look_over;
  logic in_scan;
  logic hit_head;
  logic hit_tags;
  logic [1:0] fin_kind;
  logic end_now;
  logic emit;
  logic ev_bv;
  logic [7:0] ev_byte;
  logic ev_end;
  logic [1:0] ev_kind;
  logic status_ev;
  result_t res;

  assign can_load = !out_valid || out_ready;
  assign window_shift = {window[31:0], in_byte};
  assign seg_pos_inc = seg_pos + 8'd1;
  assign look_sum = {1'b0, pkt_len} + {9'd0, rdata};
  assign look_over = look_sum > {1'b0, max_pkt};
  assign in_scan = (phase == PH_ADV) || (phase == PH_LOOK);
  assign last_flag = in_scan ? pend_last : in_last;
  assign in_ready = ctrl.take;

  opd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_SEGMENTS)
  ) u_lacing (
    .clk(clk),
    .we(ctrl.take && (phase == PH_TABLE)),
    .waddr(seg_pos[SEG_AW-1:0]),
    .wdata(in_byte),
    .re(ctrl.re),
    .raddr((phase == PH_ADV) ? seg_pos[SEG_AW-1:0] : seg_pos_inc[SEG_AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    phase_next = phase;
    ctrl = '0;
    unique case (phase)
      PH_SEARCH: begin
        if (in_valid && can_load) begin
          ctrl.take = 1'b1;
          ctrl.fin = 1'b1;
          if (window_shift == SYNC_PAGE) begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (in_valid && can_load) begin
          ctrl.take = 1'b1;
          ctrl.fin = 1'b1;
          if (hdr_pos >= COUNT_BYTE_POS) begin
            if (in_byte == 8'd0) begin
              phase_next = PH_SEARCH;
            end else if (in_byte > 8'(MAX_SEGMENTS)) begin
              ctrl.raise = 1'b1;
            end else begin
              phase_next = PH_TABLE;
            end
          end
        end
      end
      PH_TABLE: begin
        if (in_valid && can_load) begin
          ctrl.take = 1'b1;
          if ({1'b0, seg_pos} + 9'd1 >= {1'b0, seg_total}) begin
            phase_next = PH_ADV;
          end else begin
            ctrl.fin = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (in_valid && can_load) begin
          ctrl.take = 1'b1;
          if (seg_left == 8'd1) begin
            phase_next = PH_ADV;
          end else begin
            ctrl.fin = 1'b1;
          end
        end
      end
      PH_ADV: begin
        if (can_load) begin
          ctrl.do_fin = pend_fin;
          if (seg_pos < seg_total) begin
            ctrl.re = 1'b1;
            phase_next = PH_LOOK;
          end else begin
            ctrl.fin = 1'b1;
            phase_next = PH_SEARCH;
          end
        end
      end
      PH_LOOK: begin
        if (can_load) begin
          if (look_over) begin
            ctrl.raise = 1'b1;
          end else if (rdata != 8'd0) begin
            ctrl.fin = 1'b1;
            phase_next = PH_BODY;
          end else begin
            ctrl.do_fin = 1'b1;
            if ({1'b0, seg_pos} + 9'd1 < {1'b0, seg_total}) begin
              ctrl.re = 1'b1;
            end else begin
              ctrl.fin = 1'b1;
              phase_next = PH_SEARCH;
            end
          end
        end
      end
      PH_DONE: begin
        ctrl.take = in_valid;
      end
      default: begin
        phase_next = PH_SEARCH;
      end
    endcase
    if (ctrl.raise) begin
      ctrl.fin = 1'b1;
      phase_next = PH_DONE;
    end else if (ctrl.fin && last_flag) begin
      if ((phase_next == PH_TABLE) || (phase_next == PH_BODY)) begin
        ctrl.raise = 1'b1;
      end
      phase_next = PH_DONE;
    end
  end

  always_comb begin
    window_next = window;
    hdr_pos_next = hdr_pos;
    seg_total_next = seg_total;
    seg_pos_next = seg_pos;
    seg_left_next = seg_left;
    cur_len_next = cur_len;
    pkt_len_next = pkt_len;
    prefix_next = prefix;
    rate_bytes_next = rate_bytes;
    head_flag_next = head_flag;
    tags_flag_next = tags_flag;
    stream_rate_next = stream_rate;
    audio_found_next = audio_found;
    pend_bv_next = pend_bv;
    pend_byte_next = pend_byte;
    pend_end_next = pend_end;
    pend_kind_next = pend_kind;
    pend_last_next = pend_last;
    pend_fin_next = pend_fin;
    end_now = 1'b0;

    hit_head = !head_flag && (pkt_len >= MAGIC_LEN) && (prefix == MAGIC_HEAD);
    hit_tags = !hit_head && !tags_flag && (pkt_len >= MAGIC_LEN) && (prefix == MAGIC_TAGS);
    if (hit_head) begin
      fin_kind = KIND_HEAD;
    end else if (hit_tags) begin
      fin_kind = KIND_TAGS;
    end else if (!head_flag || !tags_flag) begin
      fin_kind = KIND_DROP;
    end else begin
      fin_kind = KIND_AUDIO;
    end

    if (ctrl.do_fin) begin
      pkt_len_next = '0;
      prefix_next = '0;
      rate_bytes_next = '0;
      if (pkt_len != 16'd0) begin
        end_now = 1'b1;
        if (hit_head) begin
          head_flag_next = 1'b1;
          if ((pkt_len < HEAD_MIN_LEN) || (rate_bytes == 32'd0)) begin
            stream_rate_next = default_rate;
          end else begin
            stream_rate_next = rate_bytes;
          end
        end else if (hit_tags) begin
          tags_flag_next = 1'b1;
        end else if (fin_kind == KIND_AUDIO) begin
          audio_found_next = 1'b1;
        end
      end
    end

    case (phase)
      PH_SEARCH: begin
        if (ctrl.take) begin
          if (window_shift == SYNC_PAGE) begin
            window_next = '0;
            hdr_pos_next = SYNC_LEN;
          end else begin
            window_next = window_shift;
          end
        end
      end
      PH_HEADER: begin
        if (ctrl.take) begin
          if (hdr_pos >= COUNT_BYTE_POS) begin
            seg_total_next = in_byte;
            seg_pos_next = '0;
            window_next = '0;
          end else begin
            hdr_pos_next = hdr_pos + 5'd1;
          end
        end
      end
      PH_TABLE: begin
        if (ctrl.take) begin
          if (phase_next == PH_ADV) begin
            seg_pos_next = '0;
            pend_bv_next = 1'b0;
            pend_end_next = 1'b0;
            pend_last_next = in_last;
            pend_fin_next = 1'b0;
          end else begin
            seg_pos_next = seg_pos_inc;
          end
        end
      end
      PH_BODY: begin
        if (ctrl.take) begin
          if (pkt_len < MAGIC_LEN) begin
            prefix_next[{pkt_len[2:0], 3'b000} +: 8] = in_byte;
          end else if ((pkt_len >= RATE_FIRST) && (pkt_len <= RATE_LAST)) begin
            rate_bytes_next[{pkt_len[1:0], 3'b000} +: 8] = in_byte;
          end
          pkt_len_next = pkt_len + 16'd1;
          seg_left_next = seg_left - 8'd1;
          if (phase_next == PH_ADV) begin
            seg_pos_next = seg_pos_inc;
            pend_bv_next = 1'b1;
            pend_byte_next = in_byte;
            pend_end_next = 1'b0;
            pend_last_next = in_last;
            pend_fin_next = (cur_len < LACE_FULL);
          end
        end
      end
      PH_ADV: begin
        if (can_load) begin
          if (phase_next != PH_LOOK) begin
            window_next = '0;
          end
        end
      end
      PH_LOOK: begin
        if (can_load && !look_over) begin
          if (rdata != 8'd0) begin
            seg_left_next = rdata;
            cur_len_next = rdata;
          end else begin
            seg_pos_next = seg_pos_inc;
            if (!ctrl.re) begin
              window_next = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (end_now) begin
      pend_end_next = 1'b1;
      pend_kind_next = fin_kind;
    end

    if (in_scan) begin
      ev_bv = pend_bv;
      ev_byte = pend_byte;
      ev_end = pend_end || end_now;
      ev_kind = end_now ? fin_kind : pend_kind;
    end else begin
      ev_bv = (phase == PH_BODY);
      ev_byte = in_byte;
      ev_end = 1'b0;
      ev_kind = KIND_HEAD;
    end
    status_ev = (phase_next == PH_DONE) && (phase != PH_DONE);
    emit = ctrl.fin && (ev_bv || ev_end || status_ev);

    res.out_byte = ev_bv ? ev_byte : 8'd0;
    res.byte_valid = ev_bv;
    res.packet_end = ev_end;
    res.packet_kind = ev_end ? ev_kind : KIND_HEAD;
    res.packet_rate = head_flag_next ? stream_rate_next : default_rate;
    if (phase_next != PH_DONE) begin
      res.stream_status = ST_RUN;
    end else if (ctrl.raise) begin
      res.stream_status = ST_SIZE_ERR;
    end else if (audio_found_next) begin
      res.stream_status = ST_OK;
    end else begin
      res.stream_status = ST_NO_AUDIO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      window <= '0;
      hdr_pos <= '0;
      seg_total <= '0;
      seg_pos <= '0;
      seg_left <= '0;
      cur_len <= '0;
      pkt_len <= '0;
      prefix <= '0;
      rate_bytes <= '0;
      head_flag <= 1'b0;
      tags_flag <= 1'b0;
      stream_rate <= DEFAULT_RATE;
      audio_found <= 1'b0;
      pend_bv <= 1'b0;
      pend_end <= 1'b0;
      pend_last <= 1'b0;
      pend_fin <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      window <= window_next;
      hdr_pos <= hdr_pos_next;
      seg_total <= seg_total_next;
      seg_pos <= seg_pos_next;
      seg_left <= seg_left_next;
      cur_len <= cur_len_next;
      pkt_len <= pkt_len_next;
      prefix <= prefix_next;
      rate_bytes <= rate_bytes_next;
      head_flag <= head_flag_next;
      tags_flag <= tags_flag_next;
      stream_rate <= stream_rate_next;
      audio_found <= audio_found_next;
      pend_bv <= pend_bv_next;
      pend_end <= pend_end_next;
      pend_last <= pend_last_next;
      pend_fin <= pend_fin_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    pend_kind <= pend_kind_next;
    if (emit) begin
      out_res <= res;
    end
  end

endmodule

// ----- hdl/ogg_opus_packet_demux.sv -----
// Channel   Handshake              Payload
// cfg       cfg_we                 cfg_index, cfg_data
// in        in_valid / in_ready    data_byte, last_byte
// out       out_valid / out_ready  out_byte, byte_valid, packet_end, packet_kind,
//                                  packet_rate, stream_status
//
// Bytes go through a four-entry input queue to the parser, one byte per cycle, but
// the parser pauses at each segment end to read lacing entries from the lacing RAM
// up to the next non-empty one or the page end.
// Reset is synchronous; the lacing RAM is not cleared.
// A stalled output stops the parser while the input queue keeps filling.
module ogg_opus_packet_demux #(
  parameter int MAX_SEGMENTS = opd_pkg::MAX_SEGMENTS_DEF
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic cfg_index,
  input logic [31:0] cfg_data,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] data_byte,
  input logic last_byte,
  output logic out_valid,
  input logic out_ready,
  output logic [7:0] out_byte,
  output logic byte_valid,
  output logic packet_end,
  output logic [1:0] packet_kind,
  output logic [31:0] packet_rate,
  output logic [1:0] stream_status
);
  import opd_pkg::*;

  logic [31:0] default_rate;
  logic [15:0] max_pkt;
  logic q_valid;
  logic q_ready;
  logic [8:0] q_data;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_rate <= DEFAULT_RATE;
      max_pkt <= DEFAULT_MAX_PKT;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT_RATE) begin
        default_rate <= cfg_data;
      end else begin
        max_pkt <= cfg_data[15:0];
      end
    end
  end

  opd_fifo #(
    .WIDTH(9),
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data({last_byte, data_byte}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data(q_data)
  );

  opd_parser #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .default_rate(default_rate),
    .max_pkt(max_pkt),
    .in_valid(q_valid),
    .in_ready(q_ready),
    .in_byte(q_data[7:0]),
    .in_last(q_data[8]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(res)
  );

  assign out_byte = res.out_byte;
  assign byte_valid = res.byte_valid;
  assign packet_end = res.packet_end;
  assign packet_kind = res.packet_kind;
  assign packet_rate = res.packet_rate;
  assign stream_status = res.stream_status;

endmodule

// ----- hdl/opd_checker.sv -----
module opd_checker (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic cfg_index,
  input logic [31:0] cfg_data,
  input logic in_valid,
  input logic in_ready,
  input logic [7:0] data_byte,
  input logic last_byte,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_byte,
  input logic byte_valid,
  input logic packet_end,
  input logic [1:0] packet_kind,
  input logic [31:0] packet_rate,
  input logic [1:0] stream_status
);
  import opd_pkg::*;

  a_kind_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_end |-> packet_kind == KIND_HEAD)
    else $error("packet kind set without packet end");

  a_byte_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("out byte not zero without byte valid");

  a_nothing_after_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && stream_status != ST_RUN |=> !out_valid)
    else $error("item delivered after final status");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ogg_opus_packet_demux opd_checker u_opd_checker (.*);
